FILE: hdl/ufr_pkg.sv
`default_nettype none

package ufr_pkg;

	localparam int unsigned CPB_W      = 16;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned DATA_BITS  = 8;
	localparam int unsigned BIT_IDX_W  = 4;
	localparam int unsigned OFFSET_W   = CPB_W + BIT_IDX_W + 1;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [CPB_W-1:0] CPB_RESET = CPB_W'(868);

	// register index, taken from paddr[2]
	localparam logic REG_CYCLES_PER_BIT = 1'b0;

	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic              line_level;
	} sample_t;

	typedef struct packed {
		logic                 byte_valid;
		logic [DATA_BITS-1:0] data_byte;
		logic                 framing_error;
	} result_t;

endpackage

`default_nettype wire

FILE: hdl/ufr_core.sv
`default_nettype none

module ufr_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [ufr_pkg::CPB_W-1:0] cycles_per_bit,
	input  wire logic                      fire,
	input  wire ufr_pkg::sample_t          sample,
	output ufr_pkg::result_t               result
);

	logic                              busy_q;
	logic [ufr_pkg::TIME_W-1:0]        frame_start_q;
	logic [ufr_pkg::BIT_IDX_W-1:0]     bit_count_q;
	logic [ufr_pkg::DATA_BITS-1:0]     shift_q;

	logic [ufr_pkg::BIT_IDX_W-1:0]     bit_next;
	logic [ufr_pkg::OFFSET_W-1:0]      offset;
	logic [ufr_pkg::TIME_W-1:0]        target;
	logic                              hit;
	logic                              at_stop;
	logic [ufr_pkg::DATA_BITS-1:0]     bit_mask;

	assign bit_next = bit_count_q + ufr_pkg::BIT_IDX_W'(1);
	assign offset   = ufr_pkg::OFFSET_W'(cycles_per_bit) * ufr_pkg::OFFSET_W'(bit_next)
	                + ufr_pkg::OFFSET_W'(cycles_per_bit >> 1);
	assign target   = frame_start_q + ufr_pkg::TIME_W'(offset);
	assign hit      = sample.sample_time >= target;
	assign at_stop  = bit_count_q >= ufr_pkg::BIT_IDX_W'(ufr_pkg::DATA_BITS);
	assign bit_mask = ufr_pkg::DATA_BITS'(sample.line_level)
	                << bit_count_q[$clog2(ufr_pkg::DATA_BITS)-1:0];

	always_comb begin
		result = '0;
		if (busy_q && hit && at_stop) begin
			result.byte_valid    = sample.line_level;
			result.data_byte     = sample.line_level ? shift_q : '0;
			result.framing_error = !sample.line_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			frame_start_q <= '0;
			bit_count_q   <= '0;
			shift_q       <= '0;
		end else if (fire) begin
			if (!busy_q) begin
				if (!sample.line_level) begin
					busy_q        <= 1'b1;
					frame_start_q <= sample.sample_time;
					bit_count_q   <= '0;
					shift_q       <= '0;
				end
			end else if (hit) begin
				if (!at_stop) begin
					shift_q     <= shift_q | bit_mask;
					bit_count_q <= bit_next;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> bit_count_q <= ufr_pkg::BIT_IDX_W'(ufr_pkg::DATA_BITS))
		else $error("bit index past stop position");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (result.byte_valid || result.framing_error) |=> !busy_q)
		else $error("frame end did not return to idle");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !busy_q && !sample.line_level |=> busy_q && bit_count_q == '0)
		else $error("start bit not taken");

endmodule

`default_nettype wire

FILE: hdl/uart_frame_receiver_top.sv
// 8N1 UART frame receiver working on timestamped line samples.
// sample channel: one transaction per line sample (sample_time, line_level),
//   accepted when sample_valid is high and sample_stall is low.
// result channel: exactly one transaction per sample, carrying byte_valid,
//   data_byte and framing_error; all zero when the sample ends no frame.
// APB port: register 0 at byte address 0, cycles_per_bit (16 bits, reset 868).
// Path: an accepted sample passes the input register, then the frame decode
//   into the result register.
// Throughput: one sample per cycle unless a result is stalled; the decode is
//   a 16x4 multiply-add, 64-bit add to the held frame start, 64-bit compare.
// Reset: receiver idle, both stages empty, divisor back to 868.
// Stall: while result_stall holds a result, the input stage still takes one
//   more sample; after that sample_stall rises until the result is taken.

`default_nettype none

module uart_frame_receiver_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output      logic                           sample_stall,
	input  wire ufr_pkg::sample_t               sample,
	output      logic                           result_valid,
	input  wire logic                           result_stall,
	output      ufr_pkg::result_t               result,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [ufr_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ufr_pkg::APB_DATA_W-1:0] pwdata,
	output      logic [ufr_pkg::APB_DATA_W-1:0] prdata,
	output      logic                           pready
);

	logic [ufr_pkg::CPB_W-1:0] cpb_q;
	logic                      valid_s1;
	ufr_pkg::sample_t          sample_s1;
	ufr_pkg::result_t          decoded;
	logic                      advance;
	logic                      reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2] == ufr_pkg::REG_CYCLES_PER_BIT;
	assign prdata  = reg_hit ? ufr_pkg::APB_DATA_W'(cpb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= ufr_pkg::CPB_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			cpb_q <= pwdata[ufr_pkg::CPB_W-1:0];
		end
	end

	assign advance      = valid_s1 && (!result_valid || !result_stall);
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	ufr_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.cycles_per_bit (cpb_q),
		.fire           (advance),
		.sample         (sample_s1),
		.result         (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!result_valid || !result_stall) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= decoded;
		end
	end

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled with room downstream");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("advanced transaction lost");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.byte_valid && result.framing_error))
		else $error("byte and framing error together");

	a_clean_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.byte_valid |-> result.data_byte == '0)
		else $error("data byte set without valid byte");

endmodule

`default_nettype wire
